// ===== hdl/text_line_end_scanner_assert.svh =====
// -----------------------------------------------------------------------------
// text_line_end_scanner assertion macros
// shared concurrent assertion forms for the line end scanner
// -----------------------------------------------------------------------------
`ifndef TEXT_LINE_END_SCANNER_ASSERT_SVH
`define TEXT_LINE_END_SCANNER_ASSERT_SVH

`ifndef ASSERT_OFF

// checked only outside reset
`define TLES_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tles assertion failed");

// checked on every edge, reset included
`define TLES_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("tles assertion failed");

`else

`define TLES_ASSERT(lbl, clk, rst, prop)
`define TLES_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== hdl/tles_pkg.sv =====
// -----------------------------------------------------------------------------
// tles_pkg
// types and constants of the text line end scanner
// -----------------------------------------------------------------------------
package tles_pkg;

   localparam int OFFSET_BITS_DEFAULT = 32;
   localparam int RSP_QUEUE_DEPTH     = 4;

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   // line ending codes, also used for the file's established kind
   localparam logic [1:0] END_NONE = 2'd0;
   localparam logic [1:0] END_LF   = 2'd1;
   localparam logic [1:0] END_CR   = 2'd2;
   localparam logic [1:0] END_CRLF = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_final_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] line_end_offset;
      logic [31:0] line_number;
      logic [1:0]  line_ending;
      logic        eol_mismatch;
      logic        end_of_run;
      logic [1:0]  file_ending_kind;
      logic [31:0] line_total;
   } rsp_type;

   // results produced for one byte, in order
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

endpackage

// ===== hdl/text_line_end_scanner.sv =====
// -----------------------------------------------------------------------------
// text_line_end_scanner
// finds CR, LF and CRLF line ends in a byte stream and reports each line
// -----------------------------------------------------------------------------
// One byte per cycle is accepted while the result queue has room: a byte
// waits in the input register, is decided by the combinational scan logic
// and its results (none, one or two) land in a four-entry result queue. A
// byte enters the scan logic only when the queue has room for two results,
// so a stalled result side backs up into req_ready after a few bytes. The
// results go from the queue to rsp_data. A CR that is not the final byte
// gives its result only with the next byte, since that byte tells CR from
// CRLF.
// -----------------------------------------------------------------------------
module text_line_end_scanner
   import tles_pkg::*;
#(
   parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // input register
   logic     in_valid_ff, in_valid_in;
   req_type  in_ff;
   logic     room;
   logic     take;
   push_type push;

   // the held byte moves into the scan logic when the queue can absorb it
   assign take      = in_valid_ff && room;
   assign req_ready = !in_valid_ff || take;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (take) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
   end

   // scan logic and file state
   tles_core #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .take  (take),
      .item  (in_ff),
      .push  (push)
   );

   // result queue toward the rsp channel
   tles_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hdl/tles_core.sv =====
// -----------------------------------------------------------------------------
// tles_core
// per-byte line end decision, file state and result formation
// -----------------------------------------------------------------------------
`include "text_line_end_scanner_assert.svh"

module tles_core
   import tles_pkg::*;
#(
   parameter int OFFSET_BITS = OFFSET_BITS_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     take,
   input  req_type  item,
   output push_type push
);

   localparam int WIDE_BITS = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;

   typedef struct packed {
      rsp_type     rsp;
      logic [31:0] lines;
      logic [1:0]  est;
      logic        bad;
   } put_type;

   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [31:0]            lines_ff, lines_in;
   logic [1:0]             est_ff, est_in;
   logic                   cr_ff, cr_in;
   logic                   err_ff, err_in;

   // one line end: check kind, bump line count, build the result
   function automatic put_type put_line(input logic [31:0] lines,
                                        input logic [1:0] est,
                                        input logic [OFFSET_BITS-1:0] off,
                                        input logic [1:0] kind,
                                        input logic last);
      put_type              p;
      logic [WIDE_BITS-1:0] off_w;
      p       = '0;
      p.est   = est;
      p.bad   = 1'b0;
      off_w   = WIDE_BITS'(off);
      if (kind != END_NONE) begin
         if (est == END_NONE) begin
            p.est = kind;
         end else if (est != kind) begin
            p.bad = 1'b1;
         end
      end
      p.lines = (lines != 32'hFFFF_FFFF) ? lines + 32'd1 : lines;
      p.rsp.line_end_offset  = (off_w > WIDE_BITS'(32'hFFFF_FFFF)) ?
                               32'hFFFF_FFFF : off_w[31:0];
      p.rsp.line_number      = lines;
      p.rsp.line_ending      = kind;
      p.rsp.eol_mismatch     = p.bad;
      p.rsp.end_of_run       = p.bad | last;
      p.rsp.file_ending_kind = p.est;
      p.rsp.line_total       = p.lines;
      return p;
   endfunction

   always_comb begin
      logic [OFFSET_BITS-1:0] pos1;
      logic [7:0]             b;
      logic                   fin;
      logic                   done;
      logic                   bad;
      logic                   do_put;
      logic [1:0]             kind;
      logic [1:0]             n;
      put_type                p;

      pos_in = pos_ff;
      lines_in = lines_ff;
      est_in = est_ff;
      cr_in = cr_ff;
      err_in = err_ff;
      push = '0;
      b = item.data_byte;
      fin = item.is_final_byte;
      pos1 = (pos_ff == '1) ? pos_ff : pos_ff + OFFSET_BITS'(1);
      done = 1'b0;
      bad = 1'b0;
      do_put = 1'b0;
      kind = END_NONE;
      n = 2'd0;
      p = '0;

      if (take) begin
         if (!err_ff) begin
            pos_in = pos1;
            cr_in = 1'b0;
            if (cr_ff) begin
               if (b == CHAR_LF) begin
                  p = put_line(lines_in, est_in, pos1, END_CRLF, fin);
                  done = 1'b1;
               end else begin
                  p = put_line(lines_in, est_in, pos_ff, END_CR, 1'b0);
                  done = p.bad;
               end
               push.first = p.rsp;
               lines_in = p.lines;
               est_in = p.est;
               bad = p.bad;
               n = 2'd1;
            end
            if (!done) begin
               if (b == CHAR_LF) begin
                  do_put = 1'b1;
                  kind = END_LF;
               end else if (b == CHAR_CR) begin
                  do_put = fin;
                  kind = END_CR;
                  cr_in = !fin;
               end else begin
                  do_put = fin;
                  kind = END_NONE;
               end
               if (do_put) begin
                  p = put_line(lines_in, est_in, pos1, kind, fin);
                  if (n == 2'd0) begin
                     push.first = p.rsp;
                  end else begin
                     push.second = p.rsp;
                  end
                  lines_in = p.lines;
                  est_in = p.est;
                  bad = bad | p.bad;
                  n = n + 2'd1;
               end
            end
            push.count = n;
            if (!fin && bad) begin
               err_in = 1'b1;
            end
         end
         // the final byte always ends the run and starts a fresh file
         if (fin) begin
            pos_in = '0;
            lines_in = '0;
            est_in = END_NONE;
            cr_in = 1'b0;
            err_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         lines_ff <= '0;
         est_ff <= END_NONE;
         cr_ff <= 1'b0;
         err_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         lines_ff <= lines_in;
         est_ff <= est_in;
         cr_ff <= cr_in;
         err_ff <= err_in;
      end
   end

   // a held CR and a latched error never coexist
   `TLES_ASSERT(a_cr_err_excl, clock, reset, !(cr_ff && err_ff))
   // bytes after a mismatch give no result
   `TLES_ASSERT(a_err_silent, clock, reset, (take && err_ff) |-> (push.count == 2'd0))
   // a mismatch leaves the error latched unless the byte was final
   `TLES_ASSERT(a_err_latch, clock, reset,
      (take && !err_ff && !item.is_final_byte && push.count != 2'd0 &&
       ((push.count == 2'd1) ? push.first.eol_mismatch : push.second.eol_mismatch))
      |=> err_ff)

endmodule

// ===== hdl/tles_rsp_fifo.sv =====
// -----------------------------------------------------------------------------
// tles_rsp_fifo
// small result queue, up to two pushes and one pop per cycle
// -----------------------------------------------------------------------------
`include "text_line_end_scanner_assert.svh"

module tles_rsp_fifo
   import tles_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     room,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data
);

   localparam int PTR_W = $clog2(RSP_QUEUE_DEPTH);
   localparam int CNT_W = $clog2(RSP_QUEUE_DEPTH + 1);

   rsp_type            mem_ff [RSP_QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in;
   logic [PTR_W-1:0]   rd_ff, rd_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = mem_ff[rd_ff];
   assign pop       = rsp_valid && rsp_ready;
   // space for a full two-result byte
   assign room      = (count_ff <= CNT_W'(RSP_QUEUE_DEPTH - 2));

   always_comb begin
      wr_in = wr_ff + PTR_W'(push.count);
      rd_in = rd_ff + PTR_W'(pop);
      count_in = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ff + PTR_W'(1)] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

   `TLES_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(RSP_QUEUE_DEPTH))
   `TLES_ASSERT(a_no_overflow, clock, reset,
      (push.count != 2'd0) |-> (count_ff + CNT_W'(push.count) - CNT_W'(pop)
                                <= CNT_W'(RSP_QUEUE_DEPTH)))

endmodule

// ===== sim/testbench.sv =====
// -----------------------------------------------------------------------------
// testbench
// text files are fed byte by byte into the line end scanner; a scoreboard
// tracks the same scan state, predicts every line result and compares the
// results as they come out, with random stalls on both channels
// -----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import tles_pkg::*;

   localparam int BYTE_TARGET  = 450;   // rough stimulus size
   localparam int QUIET_BYTES  = 40;    // last bytes are sent with no idling
   localparam int STUCK_LIMIT  = 5000;  // cycles with no transfer at all
   localparam int SETTLE_TIME  = 20;    // cycles after the last result
   localparam int REPORT_LIMIT = 10;

   // one byte waiting to be sent, optionally held until all lines are out
   typedef struct {
      req_type req;
      bit      hold_for_drain;
   } byte_item;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   byte_item   bytes_to_send[$];
   byte_item   next_byte;
   logic [7:0] file_bytes[$];
   rsp_type    lines_due[$];

   // scoreboard copy of the scan state
   logic [31:0] scan_pos;
   logic [31:0] scan_lines;
   logic [1:0]  scan_kind;
   bit          scan_cr_held;
   bit          scan_halted;

   int fault_count  = 0;
   int stuck_cycles = 0;
   bit timed_out    = 1'b0;
   bit quiet_tail   = 1'b0;

   // idle burst and busy stretch counters of each side
   int send_gap  = 0;
   int send_run  = 0;
   int take_gap  = 0;
   int take_run  = 0;

   text_line_end_scanner dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // line prediction
   // ---------------------------------------------------------------------------

   function automatic void clear_scan();
      scan_pos     = '0;
      scan_lines   = '0;
      scan_kind    = END_NONE;
      scan_cr_held = 1'b0;
      scan_halted  = 1'b0;
   endfunction

   // offset counter stops at all ones
   function automatic logic [31:0] step_offset(logic [31:0] pos);
      return (pos == '1) ? pos : pos + 32'd1;
   endfunction

   // records one finished line; returns 1 when its ending breaks the file's kind
   function automatic bit record_line(logic [31:0] end_off, logic [1:0] ending, bit last);
      rsp_type line;
      bit      wrong;
      wrong = 1'b0;
      line.line_number = scan_lines;
      // the file-end pseudo ending is never checked against the file's kind
      if (ending != END_NONE) begin
         if (scan_kind == END_NONE)
            scan_kind = ending;
         else if (scan_kind != ending)
            wrong = 1'b1;
      end
      if (scan_lines != '1)
         scan_lines = scan_lines + 32'd1;
      line.line_end_offset  = end_off;
      line.line_ending      = ending;
      line.eol_mismatch     = wrong;
      line.end_of_run       = wrong | last;
      line.file_ending_kind = scan_kind;
      line.line_total       = scan_lines;
      lines_due.push_back(line);
      return wrong;
   endfunction

   // the final byte starts a new file; a mismatch before it halts the scan
   function automatic void close_step(bit wrong, bit last);
      if (last)
         clear_scan();
      else if (wrong)
         scan_halted = 1'b1;
   endfunction

   // predicts the lines that one transferred byte completes
   function automatic void scan_byte(req_type item);
      logic [31:0] here;
      bit          wrong;
      bit          last;
      last = item.is_final_byte;
      // after a mismatch bytes are dropped until the file ends
      if (scan_halted) begin
         if (last)
            clear_scan();
         return;
      end
      here     = scan_pos;
      scan_pos = step_offset(here);
      // a held CR is settled by this byte: CRLF, or a plain CR line first
      if (scan_cr_held) begin
         scan_cr_held = 1'b0;
         if (item.data_byte == CHAR_LF) begin
            wrong = record_line(step_offset(here), END_CRLF, last);
            close_step(wrong, last);
            return;
         end
         wrong = record_line(here, END_CR, 1'b0);
         if (wrong) begin
            close_step(wrong, last);
            return;
         end
      end
      if (item.data_byte == CHAR_LF) begin
         wrong = record_line(step_offset(here), END_LF, last);
      end else if (item.data_byte == CHAR_CR) begin
         // wait for the next byte unless the file ends here
         if (!last) begin
            scan_cr_held = 1'b1;
            return;
         end
         wrong = record_line(step_offset(here), END_CR, 1'b1);
      end else if (last) begin
         wrong = record_line(step_offset(here), END_NONE, 1'b1);
      end else begin
         return;
      end
      close_step(wrong, last);
   endfunction

   // ---------------------------------------------------------------------------
   // stimulus building
   // ---------------------------------------------------------------------------

   // moves the collected file into the send queue, final flag on its last byte
   task automatic queue_file(bit hold);
      byte_item item;
      for (int i = 0; i < file_bytes.size(); i++) begin
         item.req.data_byte     = file_bytes[i];
         item.req.is_final_byte = (i == file_bytes.size() - 1);
         item.hold_for_drain    = hold && (i == 0);
         bytes_to_send.push_back(item);
      end
      file_bytes.delete();
   endtask

   // any byte that is not a line end
   function automatic logic [7:0] text_byte();
      logic [7:0] b;
      do
         b = 8'($urandom_range(0, 255));
      while (b == CHAR_CR || b == CHAR_LF);
      return b;
   endfunction

   function automatic void push_ending(logic [1:0] ending);
      case (ending)
         END_LF: begin
            file_bytes.push_back(CHAR_LF);
         end
         END_CR: begin
            file_bytes.push_back(CHAR_CR);
         end
         END_CRLF: begin
            file_bytes.push_back(CHAR_CR);
            file_bytes.push_back(CHAR_LF);
         end
         default: begin
         end
      endcase
   endfunction

   // mostly consistent files with random text, some with a wrong ending,
   // some plain noise with lots of line end bytes
   task automatic make_random_file();
      logic [1:0] kind;
      logic [1:0] ending;
      int         lines;
      int         len;
      if ($urandom_range(0, 7) == 0) begin
         len = $urandom_range(1, 12);
         repeat (len) begin
            if ($urandom_range(0, 2) == 0)
               file_bytes.push_back($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
            else
               file_bytes.push_back(8'($urandom_range(0, 255)));
         end
      end else begin
         kind  = 2'($urandom_range(1, 3));
         lines = $urandom_range(0, 6);
         repeat (lines) begin
            len = $urandom_range(0, 5);
            repeat (len) file_bytes.push_back(text_byte());
            ending = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(1, 3)) : kind;
            push_ending(ending);
         end
         // unterminated last line, or one byte so the file is never empty
         if ($urandom_range(0, 1) == 1) begin
            len = $urandom_range(1, 4);
            repeat (len) file_bytes.push_back(text_byte());
         end else if (file_bytes.size() == 0) begin
            file_bytes.push_back(text_byte());
         end
      end
      queue_file($urandom_range(0, 11) == 0);
   endtask

   task automatic make_directed_files();
      // LF file with a zero byte, ending on an LF
      file_bytes = '{CHAR_LF, 8'h00, CHAR_LF};
      queue_file(1'b0);
      // CRLF file whose final LF completes a CRLF
      file_bytes = '{CHAR_CR, CHAR_LF, 8'hFF, CHAR_CR, CHAR_LF};
      queue_file(1'b0);
      // CR settled by a text byte, then a CR as final byte
      file_bytes = '{CHAR_CR, 8'h78, CHAR_CR};
      queue_file(1'b0);
      // held CR settled by a text final byte: two lines in one step
      file_bytes = '{CHAR_CR, CHAR_CR, 8'h41};
      queue_file(1'b0);
      // held CR followed by a CR as final byte
      file_bytes = '{CHAR_CR, CHAR_CR};
      queue_file(1'b1);
      // CR after an LF file: mismatch, then bytes dropped until the end
      file_bytes = '{CHAR_LF, CHAR_CR, 8'h71, 8'h72, CHAR_LF, 8'h80};
      queue_file(1'b0);
      // mismatch on the final byte
      file_bytes = '{CHAR_CR, CHAR_LF, CHAR_LF};
      queue_file(1'b0);
      // one byte file, no line ending
      file_bytes = '{8'h55};
      queue_file(1'b0);
      // mismatching held CR found by the final byte
      file_bytes = '{CHAR_LF, CHAR_CR, 8'h7F};
      queue_file(1'b0);
   endtask

   // ---------------------------------------------------------------------------
   // request driver
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
         send_gap  = 0;
         send_run  = 0;
      end else begin
         // predict the lines of the byte taken at this edge
         if (req_valid && req_ready)
            scan_byte(req_data);
         // a new byte is only offered when the current one is gone
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap  = send_gap - 1;
               req_valid <= 1'b0;
            end else if (bytes_to_send.size() != 0 &&
                         (!bytes_to_send[0].hold_for_drain || lines_due.size() == 0)) begin
               next_byte = bytes_to_send.pop_front();
               req_valid <= 1'b1;
               req_data  <= next_byte.req;
               // idle bursts alternate with stretches of back-to-back bytes
               if (send_run > 0)
                  send_run = send_run - 1;
               else if (!quiet_tail) begin
                  if ($urandom_range(0, 2) == 0)
                     send_gap = $urandom_range(1, 11);
                  else
                     send_run = $urandom_range(1, 30);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
      quiet_tail <= (bytes_to_send.size() < QUIET_BYTES);
   end

   // ---------------------------------------------------------------------------
   // result monitor
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         take_gap  = 0;
         take_run  = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (lines_due.size() == 0) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT)
                  $display("unexpected line: offset %0d number %0d ending %0d",
                           rsp_data.line_end_offset, rsp_data.line_number,
                           rsp_data.line_ending);
            end else begin
               want = lines_due.pop_front();
               if (rsp_data.line_end_offset  !== want.line_end_offset  ||
                   rsp_data.line_number      !== want.line_number      ||
                   rsp_data.line_ending      !== want.line_ending      ||
                   rsp_data.eol_mismatch     !== want.eol_mismatch     ||
                   rsp_data.end_of_run       !== want.end_of_run       ||
                   rsp_data.file_ending_kind !== want.file_ending_kind ||
                   rsp_data.line_total       !== want.line_total) begin
                  fault_count++;
                  if (fault_count <= REPORT_LIMIT) begin
                     $display("line mismatch, expected: off %0d num %0d end %0d mis %0b run %0b kind %0d total %0d",
                              want.line_end_offset, want.line_number, want.line_ending,
                              want.eol_mismatch, want.end_of_run, want.file_ending_kind,
                              want.line_total);
                     $display("                 actual: off %0d num %0d end %0d mis %0b run %0b kind %0d total %0d",
                              rsp_data.line_end_offset, rsp_data.line_number,
                              rsp_data.line_ending, rsp_data.eol_mismatch,
                              rsp_data.end_of_run, rsp_data.file_ending_kind,
                              rsp_data.line_total);
                  end
               end
            end
         end
         // receiver back pressure in random bursts
         if (take_gap > 0) begin
            take_gap  = take_gap - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (take_run > 0)
               take_run = take_run - 1;
            else if (!quiet_tail) begin
               if ($urandom_range(0, 2) == 0)
                  take_gap = $urandom_range(1, 11);
               else
                  take_run = $urandom_range(1, 30);
            end
         end
      end
   end

   // count cycles with no transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stuck_cycles <= 0;
      else
         stuck_cycles <= stuck_cycles + 1;
   end

   // ---------------------------------------------------------------------------
   // sequence and end of run
   // ---------------------------------------------------------------------------
   initial begin
      clear_scan();
      make_directed_files();
      while (bytes_to_send.size() < BYTE_TARGET)
         make_random_file();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      fork
         begin
            // all bytes sent and every predicted line seen
            do
               @(posedge clock);
            while (bytes_to_send.size() != 0 || req_valid || lines_due.size() != 0);
            repeat (SETTLE_TIME) @(posedge clock);
         end
         begin
            do
               @(posedge clock);
            while (stuck_cycles < STUCK_LIMIT);
            timed_out = 1'b1;
         end
      join_any
      disable fork;

      // lines still owed count as failures
      if (lines_due.size() != 0) begin
         fault_count++;
         $display("%0d expected lines never arrived", lines_due.size());
      end

      if (!timed_out && fault_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
